// ----- rtl/ialu_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ialu package
// shared types, opcodes and error codes of the integer alu
// ----------------------------------------------------------------------------
package ialu_pkg;
    localparam int W = 32;
    localparam int CW = $clog2(W + 1);

    typedef enum logic [4:0] {
        OP_ADD = 5'd0, OP_SUB = 5'd1, OP_MUL = 5'd2, OP_DIV = 5'd3,
        OP_MOD = 5'd4, OP_POW = 5'd5, OP_LOG = 5'd6, OP_LT = 5'd7,
        OP_GT = 5'd8, OP_LE = 5'd9, OP_GE = 5'd10, OP_EQ = 5'd11,
        OP_NE = 5'd12, OP_MIN = 5'd13, OP_MAX = 5'd14, OP_NEG = 5'd15,
        OP_ABS = 5'd16, OP_SGN = 5'd17
    } t_op;

    typedef enum logic [1:0] {
        ERR_OK = 2'd0, ERR_DIV0 = 2'd1, ERR_LOG = 2'd2, ERR_POW0 = 2'd3
    } t_err;

    typedef enum logic [2:0] {
        S_IDLE, S_DIV, S_POW, S_LOGD, S_LOGC, S_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;     // capture operands, run single-cycle ops
        logic div_step; // one restoring division bit, or the single mul step
        logic div_init; // start a division of r_n by base (log)
        logic pow_step; // one square-and-multiply step
        logic log_next; // count one more division into the result
        logic fin;      // present result, raise o_valid
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic need_div;
        logic need_pow;
        logic need_log;
        logic div_last;
        logic pow_last;
        logic log_more;
    } t_stat;
endpackage

// ----- rtl/ialu_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ialu controller
// sequences the multiply, iterative divide, power and logarithm
// ----------------------------------------------------------------------------
module ialu_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  ialu_pkg::t_stat i_stat,
    output ialu_pkg::t_cmd  o_cmd
);
    import ialu_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (start) n_state = S_DONE;
            S_DONE: begin
                if (i_stat.need_div)      n_state = S_DIV;
                else if (i_stat.need_pow) n_state = S_POW;
                else if (i_stat.need_log) n_state = S_LOGC;
                else                      n_state = S_IDLE;
            end
            S_DIV:  if (i_stat.div_last) n_state = S_IDLE;
            S_POW:  if (i_stat.pow_last) n_state = S_IDLE;
            S_LOGC: n_state = i_stat.log_more ? S_LOGD : S_IDLE;
            S_LOGD: if (i_stat.div_last) n_state = S_LOGC;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        busy  = (r_state != S_IDLE);
        case (r_state)
            S_IDLE: o_cmd.load = start;
            S_DONE: begin
                o_cmd.fin      = !(i_stat.need_div || i_stat.need_pow || i_stat.need_log);
                o_cmd.div_init = i_stat.need_log;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                o_cmd.fin      = i_stat.div_last;
            end
            S_POW: begin
                o_cmd.pow_step = 1'b1;
                o_cmd.fin      = i_stat.pow_last;
            end
            S_LOGC: begin
                o_cmd.log_next = i_stat.log_more;
                o_cmd.fin      = !i_stat.log_more;
            end
            S_LOGD: begin
                o_cmd.div_step = 1'b1;
                o_cmd.div_init = i_stat.div_last;
            end
            default: ;
        endcase
    end

    a_fin_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.fin |=> r_state == S_IDLE) else $error("fin not final");
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> r_state == S_DONE) else $error("load path");
    a_step_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.div_step && o_cmd.pow_step)) else $error("step clash");
endmodule

// ----- rtl/ialu_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ialu datapath
// operand registers, single-cycle ops, shared divider, multiplier
// ----------------------------------------------------------------------------
module ialu_dp (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [4:0]             i_operation,
    input  logic [ialu_pkg::W-1:0] i_operand_a,
    input  logic [ialu_pkg::W-1:0] i_operand_b,
    input  ialu_pkg::t_cmd         i_cmd,
    output ialu_pkg::t_stat        o_stat,
    output logic                   o_valid,
    output logic [ialu_pkg::W-1:0] o_value,
    output logic [1:0]             o_error
);
    import ialu_pkg::*;

    logic [W-1:0]  r_a, r_b, r_res, r_n;
    logic [4:0]    r_op;
    logic [1:0]    r_err;
    logic          r_nq;      // negate quotient/remainder at the end
    logic          r_vld;
    // divider
    logic [W-1:0]  r_dvd, r_dvs, r_rem;
    logic [CW-1:0] r_cnt;
    // power
    logic [W-1:0]  r_acc, r_sq, r_exp;
    logic          r_mph;     // 0: acc*sq phase, 1: sq*sq phase
    logic [W-1:0]  n_res;
    logic [1:0]    n_err;
    logic          lt_ab, lt_ba;
    logic [W-1:0]  ma, mb;
    logic [W:0]    trial;
    logic [W-1:0]  rem_sh;
    logic [W-1:0]  mul_x, mul_y, mul_p;

    localparam logic [W-1:0] ONE  = W'(1);
    localparam logic [W-1:0] MONE = '1;

    assign lt_ab = $signed(i_operand_a) < $signed(i_operand_b);
    assign lt_ba = $signed(i_operand_b) < $signed(i_operand_a);
    assign ma = i_operand_a[W-1] ? -i_operand_a : i_operand_a;
    assign mb = i_operand_b[W-1] ? -i_operand_b : i_operand_b;

    // single-cycle results
    always_comb begin
        n_res = '0;
        n_err = ERR_OK;
        case (i_operation)
            OP_ADD: n_res = i_operand_a + i_operand_b;
            OP_SUB: n_res = i_operand_a - i_operand_b;
            OP_DIV, OP_MOD: if (i_operand_b == '0) n_err = ERR_DIV0;
            OP_POW: begin
                if (i_operand_b[W-1]) begin
                    if (i_operand_a == ONE) n_res = ONE;
                    else if (i_operand_a == MONE) n_res = i_operand_b[0] ? MONE : ONE;
                    else if (i_operand_a == '0) n_err = ERR_POW0;
                end
            end
            OP_LOG: if (i_operand_a[W-1] || i_operand_a <= ONE || i_operand_b[W-1]
                        || i_operand_b == '0) n_err = ERR_LOG;
            OP_LT:  n_res = W'(lt_ab);
            OP_GT:  n_res = W'(lt_ba);
            OP_LE:  n_res = W'(!lt_ba);
            OP_GE:  n_res = W'(!lt_ab);
            OP_EQ:  n_res = W'(i_operand_a == i_operand_b);
            OP_NE:  n_res = W'(i_operand_a != i_operand_b);
            OP_MIN: n_res = lt_ba ? i_operand_b : i_operand_a;
            OP_MAX: n_res = lt_ab ? i_operand_b : i_operand_a;
            OP_NEG: n_res = -i_operand_a;
            OP_ABS: n_res = ma;
            OP_SGN: n_res = (i_operand_a == '0) ? '0 : (i_operand_a[W-1] ? MONE : ONE);
            default: n_res = '0;
        endcase
    end

    // shared 32x32 low-half multiplier: mul op, acc*sq, sq*sq
    always_comb begin
        mul_x = r_a;
        mul_y = r_b;
        if (r_op == OP_POW) begin
            mul_x = r_mph ? r_sq : r_acc;
            mul_y = r_sq;
        end
    end
    assign mul_p = mul_x * mul_y;

    assign rem_sh = {r_rem[W-2:0], r_dvd[W-1]};
    assign trial  = {1'b0, rem_sh} - {1'b0, r_dvs};

    assign o_stat.need_div = (r_op == OP_DIV || r_op == OP_MOD || r_op == OP_MUL)
                             && r_err == ERR_OK && r_cnt != '0;
    assign o_stat.need_pow = r_op == OP_POW && !r_b[W-1] && r_exp != '0;
    assign o_stat.need_log = r_op == OP_LOG && r_err == ERR_OK;
    assign o_stat.div_last = r_cnt == CW'(1);
    assign o_stat.pow_last = r_mph && (r_exp >> 1) == '0;
    assign o_stat.log_more = r_n >= r_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_cmd.fin;
        end
        if (i_cmd.load) begin
            r_op  <= i_operation;
            r_a   <= i_operand_a;
            r_b   <= i_operand_b;
            r_res <= n_res;
            r_err <= n_err;
            r_n   <= i_operand_b;
            r_acc <= ONE;
            r_sq  <= i_operand_a;
            r_exp <= i_operand_b;
            r_mph <= 1'b0;
            r_dvd <= ma;
            r_dvs <= mb;
            r_rem <= '0;
            r_nq  <= (i_operation == OP_DIV) ? (i_operand_a[W-1] ^ i_operand_b[W-1])
                                              : i_operand_a[W-1];
            // mul takes a single step through the div slot (cnt 1)
            r_cnt <= (i_operation == OP_MUL) ? CW'(1)
                   : (i_operation == OP_DIV || i_operation == OP_MOD) ? CW'(W) : '0;
        end
        if (i_cmd.div_step && i_cmd.div_init) begin
            // log: final quotient bit lands in r_n and is the next dividend
            r_n   <= {r_dvd[W-2:0], !trial[W]};
            r_dvd <= {r_dvd[W-2:0], !trial[W]};
            r_rem <= '0;
            r_cnt <= CW'(W);
        end else if (i_cmd.div_init) begin
            r_dvd <= r_n;
            r_dvs <= r_a;
            r_rem <= '0;
            r_cnt <= CW'(W);
        end else if (i_cmd.div_step && r_op != OP_MUL) begin
            r_dvd <= {r_dvd[W-2:0], !trial[W]};
            r_rem <= trial[W] ? rem_sh : trial[W-1:0];
            r_cnt <= r_cnt - CW'(1);
        end else if (i_cmd.div_step) begin
            r_res <= mul_p;
            r_cnt <= '0;
        end
        if (i_cmd.pow_step) begin
            if (!r_mph) begin
                if (r_exp[0]) r_acc <= mul_p;
            end else begin
                r_sq  <= mul_p;
                r_exp <= r_exp >> 1;
            end
            r_mph <= !r_mph;
        end
        if (i_cmd.log_next) begin
            r_res <= r_res + ONE;
        end
    end

    always_comb begin
        o_value = r_res;
        o_error = r_err;
        if (r_err == ERR_OK) begin
            if (r_op == OP_DIV)      o_value = r_nq ? -r_dvd : r_dvd;
            else if (r_op == OP_MOD) o_value = r_nq ? -r_rem : r_rem;
            else if (r_op == OP_POW && !r_b[W-1]) o_value = r_acc;
        end
    end
    assign o_valid = r_vld;

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_error != ERR_OK |-> o_value == '0) else $error("err value");
    a_div0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (r_op == OP_DIV || r_op == OP_MOD) && r_b == '0 |-> o_error == ERR_DIV0)
        else $error("div0");
    a_vld_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("valid pulse");
endmodule

// ----- rtl/integer_alu_with_pow_log.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer alu with pow and log
// signed 32-bit alu with iterative divide, power and floor logarithm
// ----------------------------------------------------------------------------
// a word is taken when start is high and busy low; its result appears on
// o_value/o_error for exactly one cycle with o_valid high, and the receiver
// cannot stall it. simple ops finish from S_DONE, mul and div and mod in
// S_DIV (one restoring divider bit per cycle), pow in S_POW per exponent bit
// up to the top set bit (one shared multiplier, acc then square), log in
// S_LOGC checks, S_LOGD divisions. busy is high until the strobe is issued.
module integer_alu_with_pow_log (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [4:0]             i_operation,
    input  logic [ialu_pkg::W-1:0] i_operand_a,
    input  logic [ialu_pkg::W-1:0] i_operand_b,
    output logic                   o_valid,
    output logic [ialu_pkg::W-1:0] o_value,
    output logic [1:0]             o_error
);
    import ialu_pkg::*;

    t_cmd  cmd;   // controller commands
    t_stat stat;  // datapath status

    ialu_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_stat(stat), .o_cmd(cmd)
    );

    ialu_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_operation(i_operation),
        .i_operand_a(i_operand_a), .i_operand_b(i_operand_b),
        .i_cmd(cmd), .o_stat(stat), .o_valid(o_valid),
        .o_value(o_value), .o_error(o_error)
    );
endmodule

// ----- tb/integer_alu_with_pow_log_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer alu with pow and log testbench
// drives a directed table and then random words through the start/busy
// port, predicts each result not typed into the table in a local model of
// the alu and compares each strobed result, field by field, with the oldest expected one
// ----------------------------------------------------------------------------
module integer_alu_with_pow_log_tb;
    import ialu_pkg::*;

    localparam int N_RANDOM   = 650;
    localparam int N_DIRECTED = 22;
    localparam int N_TOTAL    = N_DIRECTED + N_RANDOM;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int DRAIN_CYCLES = 1200;   // longer than the slowest log word

    // one row of the directed table; typed-in result only where has_res is set
    typedef struct {
        logic [4:0]   op;
        logic [W-1:0] a;
        logic [W-1:0] b;
        bit           has_res;
        logic [W-1:0] res_value;
        logic [1:0]   res_error;
    } t_row;

    typedef struct {
        logic [W-1:0] value;
        logic [1:0]   error;
    } t_result;

    localparam logic [W-1:0] MOST_NEG = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] MOST_POS = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINUS_1  = '1;
    localparam logic [4:0]   OP_UNUSED_LO = 5'd18;
    localparam logic [4:0]   OP_UNUSED_HI = 5'd31;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         start = 1'b0;
    logic         busy;
    logic [4:0]   i_operation = '0;
    logic [W-1:0] i_operand_a = '0;
    logic [W-1:0] i_operand_b = '0;
    logic         o_valid;
    logic [W-1:0] o_value;
    logic [1:0]   o_error;

    t_row    directed [N_DIRECTED];
    t_result pending_results [$];
    t_result cur_res;               // typed-in result of the word on the port
    bit      cur_has_res = 0;

    int  words_sent = 0;
    int  mismatches = 0;
    int  cycles = 0;
    bit  pressure_done = 0;
    bit  pressure_wait = 0;

    integer_alu_with_pow_log DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_operation (i_operation),
        .i_operand_a (i_operand_a),
        .i_operand_b (i_operand_b),
        .o_valid     (o_valid),
        .o_value     (o_value),
        .o_error     (o_error)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // local model of the alu: one word in, one result out
    function automatic t_result alu_result(input logic [4:0] op, input logic [W-1:0] a,
                                           input logic [W-1:0] b);
        t_result      r;
        logic [W-1:0] ua, ub, acc, sq, ex, n;
        int           cnt;
        r.value = '0;
        r.error = ERR_OK;
        ua = a[W-1] ? -a : a;
        ub = b[W-1] ? -b : b;
        case (op)
            OP_ADD: r.value = a + b;
            OP_SUB: r.value = a - b;
            OP_MUL: r.value = a * b;
            OP_DIV, OP_MOD: begin
                if (b == '0) begin
                    r.error = ERR_DIV0;
                end else if (op == OP_DIV) begin
                    r.value = ua / ub;
                    if (a[W-1] != b[W-1]) r.value = -r.value;
                end else begin
                    r.value = ua % ub;
                    if (a[W-1]) r.value = -r.value;
                end
            end
            OP_POW: begin
                if (b[W-1]) begin
                    // negative exponent: only the unit bases survive
                    if (a == 1) r.value = 1;
                    else if (a == MINUS_1) r.value = b[0] ? MINUS_1 : 1;
                    else if (a == '0) r.error = ERR_POW0;
                    else r.value = '0;
                end else begin
                    acc = 1;
                    sq = a;
                    ex = b;
                    while (ex != '0) begin
                        if (ex[0]) acc = acc * sq;
                        sq = sq * sq;
                        ex = ex >> 1;
                    end
                    r.value = acc;
                end
            end
            OP_LOG: begin
                if (a[W-1] || a <= 1 || b[W-1] || b == '0) begin
                    r.error = ERR_LOG;
                end else begin
                    n = b;
                    cnt = 0;
                    while (n >= a) begin
                        n = n / a;
                        cnt++;
                    end
                    r.value = W'(cnt);
                end
            end
            OP_LT:  r.value = W'($signed(a) <  $signed(b));
            OP_GT:  r.value = W'($signed(a) >  $signed(b));
            OP_LE:  r.value = W'($signed(a) <= $signed(b));
            OP_GE:  r.value = W'($signed(a) >= $signed(b));
            OP_EQ:  r.value = W'(a == b);
            OP_NE:  r.value = W'(a != b);
            OP_MIN: r.value = ($signed(b) < $signed(a)) ? b : a;
            OP_MAX: r.value = ($signed(a) < $signed(b)) ? b : a;
            OP_NEG: r.value = -a;
            OP_ABS: r.value = ua;
            OP_SGN: r.value = (a == '0) ? '0 : (a[W-1] ? MINUS_1 : 1);
            default: r.value = '0;
        endcase
        if (r.error != ERR_OK) r.value = '0;
        return r;
    endfunction

    // operand drawn from edge values, small numbers or full random bits
    function automatic logic [W-1:0] rand_operand();
        case ($urandom_range(0, 9))
            0: return MOST_NEG;
            1: return MOST_POS;
            2: return MINUS_1;
            3: return W'($urandom_range(0, 2));
            4, 5: return W'($urandom_range(0, 40) - 20);
            default: return $urandom;
        endcase
    endfunction

    // next random word; log words mostly use big bases to keep the run short
    task automatic rand_word(output logic [4:0] op, output logic [W-1:0] a,
                             output logic [W-1:0] b);
        if ($urandom_range(0, 19) == 0)
            op = 5'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
        else
            op = 5'($urandom_range(OP_ADD, OP_SGN));
        a = rand_operand();
        b = rand_operand();
        if (op == OP_LOG && $urandom_range(0, 3) != 0) begin
            a = ($urandom_range(0, 7) == 0) ? $urandom_range(2, 3) : $urandom_range(2, 70000);
            b = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(1, 100000);
        end
        if (op == OP_POW && $urandom_range(0, 1) == 0)
            b = $urandom_range(0, 40);
    endtask

    // idle percentage of the sender, by quarter of the run
    function automatic int idle_pct(input int idx);
        case ((idx * 4) / N_TOTAL)
            0: return 0;
            1: return 46;
            2: return 8;
            default: return 46;
        endcase
    endfunction

    initial begin
        // extremes and special cases of the arithmetic ops, abs, neg, sgn, min and an unused opcode
        directed[0]  = '{OP_ADD, MOST_POS, 1, 1, MOST_NEG, ERR_OK};
        directed[1]  = '{OP_SUB, MOST_NEG, 1, 1, MOST_POS, ERR_OK};
        directed[2]  = '{OP_MUL, MOST_NEG, MINUS_1, 1, MOST_NEG, ERR_OK};
        directed[3]  = '{OP_DIV, MOST_NEG, MINUS_1, 1, MOST_NEG, ERR_OK};
        directed[4]  = '{OP_MOD, MOST_NEG, MINUS_1, 1, 0, ERR_OK};
        directed[5]  = '{OP_DIV, 7, 0, 1, 0, ERR_DIV0};
        directed[6]  = '{OP_MOD, MINUS_1, 0, 1, 0, ERR_DIV0};
        directed[7]  = '{OP_DIV, -7, 2, 0, 0, ERR_OK};
        directed[8]  = '{OP_MOD, -7, 2, 0, 0, ERR_OK};
        directed[9]  = '{OP_POW, 0, MINUS_1, 1, 0, ERR_POW0};
        directed[10] = '{OP_POW, MINUS_1, -3, 1, MINUS_1, ERR_OK};
        directed[11] = '{OP_POW, 1, MOST_NEG, 1, 1, ERR_OK};
        directed[12] = '{OP_POW, 0, 0, 1, 1, ERR_OK};
        directed[13] = '{OP_POW, 3, MOST_POS, 0, 0, ERR_OK};
        directed[14] = '{OP_LOG, 1, 100, 1, 0, ERR_LOG};
        directed[15] = '{OP_LOG, 10, 0, 1, 0, ERR_LOG};
        directed[16] = '{OP_LOG, 2, MOST_POS, 1, 30, ERR_OK};
        directed[17] = '{OP_ABS, MOST_NEG, 0, 1, MOST_NEG, ERR_OK};
        directed[18] = '{OP_NEG, MOST_NEG, 0, 1, MOST_NEG, ERR_OK};
        directed[19] = '{OP_SGN, MOST_NEG, MOST_POS, 1, MINUS_1, ERR_OK};
        directed[20] = '{OP_MIN, MOST_NEG, MOST_POS, 1, MOST_NEG, ERR_OK};
        directed[21] = '{OP_UNUSED_HI, MOST_POS, MOST_POS, 1, 0, ERR_OK};

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // all words in, then drain and let the block settle
        while (words_sent < N_TOTAL || pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("integer_alu_with_pow_log regression: pass");
        else
            $display("integer_alu_with_pow_log regression: fail");
        $finish;
    end

    // sender: keep a word on the port until it is taken, then pick the next
    always @(posedge i_clk) begin
        logic [4:0]   op;
        logic [W-1:0] a, b;
        t_result      res;
        bit           taken, hold_off;
        int           idx;
        if (i_rst_n) begin
            taken = start && !busy;
            idx = words_sent;
            if (taken) begin
                res = cur_has_res ? cur_res : alu_result(i_operation, i_operand_a, i_operand_b);
                pending_results.push_back(res);
                idx = idx + 1;
                words_sent <= idx;
            end
            // one pause in the middle until every result is back
            hold_off = 0;
            if (!pressure_done && idx == N_TOTAL / 2) begin
                if (!pressure_wait) pressure_wait <= 1;
                if (pending_results.size() != 0 || !pressure_wait) hold_off = 1;
                else pressure_done <= 1;
            end
            if (start && !taken) begin
                // word still waiting on busy
            end else if (idx < N_TOTAL && !hold_off &&
                         $urandom_range(0, 99) >= idle_pct(idx)) begin
                if (idx < N_DIRECTED) begin
                    op = directed[idx].op;
                    a = directed[idx].a;
                    b = directed[idx].b;
                    cur_has_res <= directed[idx].has_res;
                    cur_res <= '{directed[idx].res_value, directed[idx].res_error};
                end else begin
                    rand_word(op, a, b);
                    cur_has_res <= 0;
                end
                i_operation <= op;
                i_operand_a <= a;
                i_operand_b <= b;
                start <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // checker: every strobe matches the oldest expected result
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result value=%h error=%0d", o_value, o_error);
            end else begin
                want = pending_results.pop_front();
                if (o_value !== want.value || o_error !== want.error) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected value=%h error=%0d, got value=%h error=%0d",
                                 want.value, want.error, o_value, o_error);
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("integer_alu_with_pow_log regression: fail");
            $finish;
        end
    end
endmodule
